### rtl/core/rrbt_pkg.sv
// Shared constants, codes and controller/datapath interface types for the byte throttle.
package rrbt_pkg;

  // Field widths
  localparam int FUNC_W      = 2;
  localparam int ID_W        = 6;
  localparam int BUD_W       = 32;
  localparam int EBUD_W      = 33;
  localparam int PB_W        = 16;
  localparam int EV_W        = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // Defaults
  localparam int              MAX_ENTRIES_DEF = 16;
  localparam logic [PB_W-1:0] PB_RESET        = 16'd1500;

  // Request function codes
  localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_TICK   = 2'd2;
  localparam logic [FUNC_W-1:0] FN_FLUSH  = 2'd3;

  // Result event codes
  localparam logic [EV_W-1:0] EV_REL   = 2'd0;
  localparam logic [EV_W-1:0] EV_FLUSH = 2'd1;
  localparam logic [EV_W-1:0] EV_FULL  = 2'd2;
  localparam logic [EV_W-1:0] EV_ACK   = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic cap;
    logic do_add;
    logic rd_head;
    logic tick_commit;
    logic scan_start;
    logic scan_step;
    logic rm_commit;
    logic ack_zero;
    logic fl_start;
    logic fl_rd;
    logic fl_out;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              empty;
    logic              out_free;
    logic              scan_done;
    logic              fl_last;
  } dp_sts_t;

endpackage

### rtl/core/rrbt_ctrl.sv
// Request sequencer: decodes the captured function and steps the datapath.
module rrbt_ctrl
  import rrbt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_EXEC    = 7'b0000010,
    S_TK_EVAL = 7'b0000100,
    S_RM_SCAN = 7'b0001000,
    S_RM_DONE = 7'b0010000,
    S_FL_RD   = 7'b0100000,
    S_FL_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Only one request in flight
  assign in_tready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.func)
          FN_ADD: begin
            if (sts.out_free) begin
              cmd.do_add = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
          FN_REMOVE: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_RM_SCAN;
          end
          FN_TICK: begin
            if (sts.empty) begin
              if (sts.out_free) begin
                cmd.ack_zero = 1'b1;
                state_nxt    = S_IDLE;
              end
            end else begin
              cmd.rd_head = 1'b1;
              state_nxt   = S_TK_EVAL;
            end
          end
          FN_FLUSH: begin
            if (sts.empty) begin
              if (sts.out_free) begin
                cmd.ack_zero = 1'b1;
                state_nxt    = S_IDLE;
              end
            end else begin
              cmd.fl_start = 1'b1;
              state_nxt    = S_FL_RD;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_TK_EVAL: begin
        if (sts.out_free) begin
          cmd.tick_commit = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_RM_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_RM_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_RM_DONE: begin
        if (sts.out_free) begin
          cmd.rm_commit = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_FL_RD: begin
        cmd.fl_rd = 1'b1;
        state_nxt = S_FL_OUT;
      end
      S_FL_OUT: begin
        if (sts.out_free) begin
          cmd.fl_out = 1'b1;
          state_nxt  = sts.fl_last ? S_IDLE : S_FL_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/rrbt_dp.sv
// Datapath: entry ring memory, head/count pointers, scan counters and result register.
module rrbt_dp
  import rrbt_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [PB_W-1:0]        cfg_data,
  input  logic [FUNC_W-1:0]      in_tuser,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [EV_W-1:0]        out_tuser,
  output logic                   out_tlast
);

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int WORD_W = ID_W + EBUD_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // Slot of the entry at a given offset from the head
  function automatic logic [IDX_W-1:0] wrap_slot(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(MAX_ENTRIES)) begin
      sum = sum - (CNT_W+1)'(MAX_ENTRIES);
    end
    return sum[IDX_W-1:0];
  endfunction

  logic [WORD_W-1:0]  mem [MAX_ENTRIES];
  logic [WORD_W-1:0]  rd_q_r;

  logic [PB_W-1:0]    pb_r;
  logic [FUNC_W-1:0]  func_r;
  logic [ID_W-1:0]    id_r;
  logic [BUD_W-1:0]   bud_r;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   kept_r, kept_nxt;
  logic [CNT_W-1:0]   iss_r, iss_nxt;
  logic               scan_vld_r, scan_vld_nxt;
  logic [CNT_W-1:0]   fl_idx_r, fl_idx_nxt;

  logic               out_vld_r;
  logic [ID_W-1:0]    out_id_r;
  logic [EV_W-1:0]    out_ev_r;
  logic               out_last_r;

  logic               rd_en, wr_en;
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic               load;
  logic [ID_W-1:0]    ld_id;
  logic [EV_W-1:0]    ld_ev;
  logic               ld_last;

  logic [ID_W-1:0]    rd_id;
  logic [EBUD_W-1:0]  rd_bud;
  logic [EBUD_W-1:0]  tick_nb;
  logic               tick_rel;
  logic               full;
  logic               issue;
  logic               fl_last;
  logic               out_free;

  assign rd_id    = rd_q_r[WORD_W-1 -: ID_W];
  assign rd_bud   = rd_q_r[EBUD_W-1:0];
  assign tick_nb  = rd_bud - EBUD_W'(pb_r);
  assign tick_rel = tick_nb[EBUD_W-1];
  assign full     = (cnt_r == CNT_MAX);
  assign issue    = (iss_r < cnt_r);
  assign fl_last  = (fl_idx_r == (cnt_r - CNT_ONE));
  assign out_free = !out_vld_r || out_tready;

  // Status to controller
  assign sts.func      = func_r;
  assign sts.empty     = (cnt_r == '0);
  assign sts.out_free  = out_free;
  assign sts.scan_done = !issue && !scan_vld_r;
  assign sts.fl_last   = fl_last;

  // Command decode: memory ports, pointer updates, result load
  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = head_r;
    wr_en        = 1'b0;
    wr_addr      = head_r;
    wr_data      = rd_q_r;
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    kept_nxt     = kept_r;
    iss_nxt      = iss_r;
    scan_vld_nxt = scan_vld_r;
    fl_idx_nxt   = fl_idx_r;
    load         = 1'b0;
    ld_id        = '0;
    ld_ev        = EV_ACK;
    ld_last      = 1'b1;

    // Add at the back, or reject when full
    if (cmd.do_add) begin
      load  = 1'b1;
      ld_id = id_r;
      if (full) begin
        ld_ev = EV_FULL;
      end else begin
        wr_en   = 1'b1;
        wr_addr = wrap_slot(head_r, cnt_r);
        wr_data = {id_r, 1'b0, bud_r};
        cnt_nxt = cnt_r + CNT_ONE;
      end
    end

    // Tick: fetch head, then charge it
    if (cmd.rd_head) begin
      rd_en   = 1'b1;
      rd_addr = head_r;
    end
    if (cmd.tick_commit) begin
      load     = 1'b1;
      ld_id    = rd_id;
      head_nxt = wrap_slot(head_r, CNT_ONE);
      if (tick_rel) begin
        ld_ev   = EV_REL;
        cnt_nxt = cnt_r - CNT_ONE;
      end else begin
        wr_en   = 1'b1;
        wr_addr = wrap_slot(head_r, cnt_r);
        wr_data = {rd_id, tick_nb};
      end
    end

    // Remove: pipelined in-place compaction, read one ahead of write
    if (cmd.scan_start) begin
      iss_nxt      = '0;
      kept_nxt     = '0;
      scan_vld_nxt = 1'b0;
    end
    if (cmd.scan_step) begin
      if (issue) begin
        rd_en   = 1'b1;
        rd_addr = wrap_slot(head_r, iss_r);
        iss_nxt = iss_r + CNT_ONE;
      end
      scan_vld_nxt = issue;
      if (scan_vld_r && (rd_id != id_r)) begin
        wr_en    = 1'b1;
        wr_addr  = wrap_slot(head_r, kept_r);
        wr_data  = rd_q_r;
        kept_nxt = kept_r + CNT_ONE;
      end
    end
    if (cmd.rm_commit) begin
      cnt_nxt = kept_r;
      load    = 1'b1;
      ld_id   = id_r;
    end

    // Empty tick or flush
    if (cmd.ack_zero) begin
      load     = 1'b1;
      head_nxt = '0;
    end

    // Flush walk
    if (cmd.fl_start) begin
      fl_idx_nxt = '0;
    end
    if (cmd.fl_rd) begin
      rd_en   = 1'b1;
      rd_addr = wrap_slot(head_r, fl_idx_r);
    end
    if (cmd.fl_out) begin
      load       = 1'b1;
      ld_id      = rd_id;
      ld_ev      = EV_FLUSH;
      ld_last    = fl_last;
      fl_idx_nxt = fl_idx_r + CNT_ONE;
      if (fl_last) begin
        cnt_nxt  = '0;
        head_nxt = '0;
      end
    end
  end

  // Entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Captured request payload
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      func_r <= in_tuser;
      id_r   <= in_tdata[ID_W-1:0];
      bud_r  <= in_tdata[ID_W +: BUD_W];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_r       <= PB_RESET;
      head_r     <= '0;
      cnt_r      <= '0;
      kept_r     <= '0;
      iss_r      <= '0;
      scan_vld_r <= 1'b0;
      fl_idx_r   <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        pb_r <= cfg_data;
      end
      head_r     <= head_nxt;
      cnt_r      <= cnt_nxt;
      kept_r     <= kept_nxt;
      iss_r      <= iss_nxt;
      scan_vld_r <= scan_vld_nxt;
      fl_idx_r   <= fl_idx_nxt;
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_id_r   <= ld_id;
      out_ev_r   <= ld_ev;
      out_last_r <= ld_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W-ID_W){1'b0}}, out_id_r};
  assign out_tuser  = out_ev_r;
  assign out_tlast  = out_last_r;

endmodule

### rtl/core/round_robin_byte_throttle.sv
// Throughput: one request at a time; the next is taken the cycle after its last result loads.
// Each result load waits while the output register holds a result that is not yet taken.
// The remove scan and flush walk are bound by the single read port of the entry memory.
// Reset: synchronous, active low; clears pointers, count and sequencer, packet size to 1500.
// Top level: round-robin byte throttle with controller, datapath and config register.
module round_robin_byte_throttle
  import rrbt_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Packet size register
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [PB_W-1:0]        cfg_data,
  // Requests
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [5:0] entry_id, [37:6] byte_budget, [39:38] zero
  input  logic [FUNC_W-1:0]      in_tuser,   // [1:0] func
  // Results
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [5:0] released_id, [7:6] zero
  output logic [EV_W-1:0]        out_tuser,  // [1:0] event_res
  output logic                   out_tlast
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  rrbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rrbt_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_data   (cfg_data),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  // A request is never taken back to back
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while previous one in flight");

  // Results only load into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_add || cmd.tick_commit || cmd.rm_commit || cmd.ack_zero || cmd.fl_out)
      |-> sts.out_free)
    else $error("result loaded over a pending result");

  // At most one memory-writing or result-loading command per cycle
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.do_add, cmd.tick_commit, cmd.scan_step, cmd.rm_commit,
              cmd.ack_zero, cmd.fl_out}))
    else $error("conflicting datapath commands");
`endif

endmodule
